// ===== sv/tcis_pkg.sv =====
// shared types and constants of the tabulated cdf inverse sampler
// no dependencies
package tcis_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int ENERGY_W    = 32;
   localparam int WEIGHT_W    = 24;
   localparam int CUM_W       = 25;
   localparam int SUM_W       = 36;
   localparam int PROD_W      = CUM_W + ENERGY_W;
   localparam int QUOT_W      = 32;
   localparam int STEP_W      = 6;
   localparam int NORM_STEPS  = 25;
   localparam int INTERP_STEPS = 32;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BELOW     = 2'd1,
      STATUS_ABOVE     = 2'd2,
      STATUS_NOT_READY = 2'd3
   } status_type;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // request to the shared divider
   typedef struct packed {
      logic [SUM_W-1:0]  rem_init;
      logic [QUOT_W-1:0] num_low;
      logic [STEP_W-1:0] steps;
      logic [SUM_W-1:0]  divisor;
   } div_req_type;

endpackage

// ===== sv/tcis_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on tcis_pkg
module tcis_div import tcis_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              div_start,
   input  div_req_type       div_req,
   output logic              div_done,
   output logic [QUOT_W-1:0] div_quotient
);

   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0] low_ff, low_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [SUM_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SUM_W:0]    trial;
   logic [SUM_W:0]    diff;

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, low_ff[QUOT_W-1]};
      diff    = trial - {1'b0, div_ff};
      if (div_start) begin
         rem_in  = div_req.rem_init;
         low_in  = div_req.num_low;
         div_in  = div_req.divisor;
         cnt_in  = div_req.steps;
         quot_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         low_in = {low_ff[QUOT_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in  = diff[SUM_W-1:0];
            quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[SUM_W-1:0];
            quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

   assign div_done     = done_ff;
   assign div_quotient = quot_ff;

endmodule

// ===== sv/tabulated_cdf_inverse_sampler_top.sv =====
// top level of the tabulated cdf inverse sampler: table memories, sequencer
// depends on tcis_pkg and tcis_div
//
// A load request (operation 0) writes one table point. The request marked
// last_point then walks the table. The first pass sums the weights. Unless
// they are all zero, a second pass normalizes each entry to Q1.24 through the
// shared divider. busy stays high for that whole walk. A sample request
// (operation 1) binary-searches the cumulative table (at most 9 probes) and
// closes the search. It then fetches the two bracketing points,
// multiplies and divides on the same shared divider. A sample on a table that
// is not ready answers in the cycle after it is taken and never raises busy.
// A sample that misses the table answers once the search closes, or after the
// fetch if its bracketing points do not rise. Each sample gives exactly one
// response, shown on rsp_valid for one cycle, in the first cycle with busy low
// again. The receiver cannot stall it, so it must take it there. Loads give no
// response.
module tabulated_cdf_inverse_sampler_top import tcis_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  logic [ENERGY_W-1:0] req_energy_point,
   input  logic [WEIGHT_W-1:0] req_point_weight,
   input  logic                req_last_point,
   input  logic [WEIGHT_W-1:0] req_random_value,
   output logic                rsp_valid,
   output logic [ENERGY_W-1:0] rsp_sampled_energy,
   output logic [1:0]          rsp_sample_status
);

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_SUM_RD   = 13'b0000000000010,
      S_SUM_ACC  = 13'b0000000000100,
      S_NRM_RD   = 13'b0000000001000,
      S_NRM_DIV  = 13'b0000000010000,
      S_NRM_WAIT = 13'b0000000100000,
      S_SRCH     = 13'b0000001000000,
      S_SRCH_CMP = 13'b0000010000000,
      S_FETCH_A  = 13'b0000100000000,
      S_FETCH_B  = 13'b0001000000000,
      S_FETCH_C  = 13'b0010000000000,
      S_MUL      = 13'b0100000000000,
      S_DIV_WAIT = 13'b1000000000000
   } state_type;

   // table memories, one shared address
   logic [ENERGY_W-1:0] energy_mem [TABLE_DEPTH];
   logic [CUM_W-1:0]    cum_mem    [TABLE_DEPTH];

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                ready_ff, ready_in;
   logic [CNT_W-1:0]    k_ff, k_in;
   logic [SUM_W-1:0]    total_ff, total_in;
   logic [SUM_W-1:0]    prefix_ff, prefix_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;
   logic [CNT_W-1:0]    mid_ff, mid_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [WEIGHT_W-1:0] r_ff, r_in;
   logic [ENERGY_W-1:0] ea_ff, ea_in;
   logic [CUM_W-1:0]    ya_ff, ya_in;
   logic [ENERGY_W-1:0] mag_ff, mag_in;
   logic [CUM_W-1:0]    dist_ff, dist_in;
   logic [CUM_W-1:0]    den_ff, den_in;
   logic                desc_ff, desc_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ENERGY_W-1:0] rsp_energy_ff, rsp_energy_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic [ENERGY_W-1:0] e_rd_ff;
   logic [CUM_W-1:0]    c_rd_ff;
   logic [ADDR_W-1:0]   mem_addr;
   logic                mem_we;
   logic                cum_only_we;
   logic [ENERGY_W-1:0] e_wdata;
   logic [CUM_W-1:0]    c_wdata;

   logic                accept;
   logic [CNT_W-1:0]    base;
   logic [CNT_W-1:0]    k_next;
   logic [SUM_W-1:0]    sum_next;
   logic [SUM_W-1:0]    pre_next;
   logic [CNT_W-1:0]    mid_calc;
   logic [CNT_W:0]      mid_sum;

   logic                div_start;
   div_req_type         div_req;
   logic                div_done;
   logic [QUOT_W-1:0]   div_quotient;

   tcis_div u_div (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_req      (div_req),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   assign accept   = start && (state_ff == S_IDLE);
   assign base     = ready_ff ? '0 : count_ff;
   assign k_next   = k_ff + 1'b1;
   assign sum_next = total_ff + SUM_W'(c_rd_ff);
   assign pre_next = prefix_ff + SUM_W'(c_rd_ff);
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc = mid_sum[CNT_W:1];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ready_in      = ready_ff;
      k_in          = k_ff;
      total_in      = total_ff;
      prefix_in     = prefix_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      idx_in        = idx_ff;
      r_in          = r_ff;
      ea_in         = ea_ff;
      ya_in         = ya_ff;
      mag_in        = mag_ff;
      dist_in       = dist_ff;
      den_in        = den_ff;
      desc_in       = desc_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = 1'b0;
      rsp_energy_in = rsp_energy_ff;
      rsp_status_in = rsp_status_ff;
      mem_addr      = k_ff[ADDR_W-1:0];
      mem_we        = 1'b0;
      cum_only_we   = 1'b0;
      e_wdata       = req_energy_point;
      c_wdata       = CUM_W'(req_point_weight);
      div_start     = 1'b0;
      div_req       = '0;

      unique case (state_ff)
         S_IDLE: begin
            mem_addr = base[ADDR_W-1:0];
            if (accept) begin
               if (req_operation == OP_LOAD) begin
                  // a load after a finished table starts a new one
                  ready_in = 1'b0;
                  count_in = base;
                  if (base < CNT_W'(TABLE_DEPTH)) begin
                     mem_we   = 1'b1;
                     count_in = base + 1'b1;
                  end
                  if (req_last_point) begin
                     k_in     = '0;
                     total_in = '0;
                     if (count_in == '0) begin
                        ready_in = 1'b1;
                     end else begin
                        state_in = S_SUM_RD;
                     end
                  end
               end else begin
                  if (!ready_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_energy_in = '0;
                     rsp_status_in = STATUS_NOT_READY;
                  end else begin
                     r_in     = req_random_value;
                     lo_in    = '0;
                     hi_in    = count_ff;
                     state_in = S_SRCH;
                  end
               end
            end
         end
         S_SUM_RD: begin
            state_in = S_SUM_ACC;
         end
         S_SUM_ACC: begin
            total_in = sum_next;
            k_in     = k_next;
            state_in = S_SUM_RD;
            if (k_next == count_ff) begin
               k_in      = '0;
               prefix_in = '0;
               // all-zero weights stay as loaded
               if (sum_next == '0) begin
                  ready_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_NRM_RD;
               end
            end
         end
         S_NRM_RD: begin
            state_in = S_NRM_DIV;
         end
         S_NRM_DIV: begin
            // prefix * 2^24 / total, quotient fits in 25 bits
            prefix_in        = pre_next;
            div_start        = 1'b1;
            div_req.rem_init = pre_next >> 1;
            div_req.num_low  = {pre_next[0], {(QUOT_W-1){1'b0}}};
            div_req.steps    = STEP_W'(NORM_STEPS);
            div_req.divisor  = total_ff;
            state_in         = S_NRM_WAIT;
         end
         S_NRM_WAIT: begin
            c_wdata = div_quotient[CUM_W-1:0];
            if (div_done) begin
               cum_only_we = 1'b1;
               k_in        = k_next;
               if (k_next == count_ff) begin
                  ready_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_NRM_RD;
               end
            end
         end
         S_SRCH: begin
            // lo ends as the number of entries at or below r
            mem_addr = mid_calc[ADDR_W-1:0];
            mid_in   = mid_calc;
            if (lo_ff == hi_ff) begin
               idx_in = ADDR_W'(lo_ff - 1'b1);
               if (lo_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_energy_in = '0;
                  rsp_status_in = STATUS_BELOW;
                  state_in      = S_IDLE;
               end else if (lo_ff >= count_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_energy_in = '0;
                  rsp_status_in = STATUS_ABOVE;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_FETCH_A;
               end
            end else begin
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (c_rd_ff <= CUM_W'(r_ff)) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SRCH;
         end
         S_FETCH_A: begin
            mem_addr = idx_ff;
            state_in = S_FETCH_B;
         end
         S_FETCH_B: begin
            mem_addr = idx_ff + 1'b1;
            ea_in    = e_rd_ff;
            ya_in    = c_rd_ff;
            state_in = S_FETCH_C;
         end
         S_FETCH_C: begin
            desc_in = e_rd_ff < ea_ff;
            mag_in  = (e_rd_ff >= ea_ff) ? e_rd_ff - ea_ff : ea_ff - e_rd_ff;
            dist_in = CUM_W'(r_ff) - ya_ff;
            den_in  = c_rd_ff - ya_ff;
            if (c_rd_ff <= ya_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_energy_in = '0;
               rsp_status_in = STATUS_ABOVE;
               state_in      = S_IDLE;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(dist_ff) * PROD_W'(mag_ff);
            state_in = S_DIV_WAIT;
            k_in     = '0;
         end
         S_DIV_WAIT: begin
            // quotient stays below the energy step, so 32 bits suffice
            if (k_ff == '0) begin
               div_start        = 1'b1;
               div_req.rem_init = SUM_W'(prod_ff[PROD_W-1:QUOT_W]);
               div_req.num_low  = prod_ff[QUOT_W-1:0];
               div_req.steps    = STEP_W'(INTERP_STEPS);
               div_req.divisor  = SUM_W'(den_ff);
               k_in             = CNT_W'(1);
            end else if (div_done) begin
               rsp_valid_in  = 1'b1;
               rsp_energy_in = desc_ff ? ea_ff - div_quotient : ea_ff + div_quotient;
               rsp_status_in = STATUS_OK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
      end
      total_ff      <= total_in;
      prefix_ff     <= prefix_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      idx_ff        <= idx_in;
      r_ff          <= r_in;
      ea_ff         <= ea_in;
      ya_ff         <= ya_in;
      mag_ff        <= mag_in;
      dist_ff       <= dist_in;
      den_ff        <= den_in;
      desc_ff       <= desc_in;
      prod_ff       <= prod_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_status_ff <= rsp_status_in;
   end

   // table memories with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         energy_mem[mem_addr] <= e_wdata;
      end
      if (mem_we || cum_only_we) begin
         cum_mem[mem_addr] <= c_wdata;
      end
      e_rd_ff <= energy_mem[mem_addr];
      c_rd_ff <= cum_mem[mem_addr];
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sampled_energy = rsp_energy_ff;
   assign rsp_sample_status  = rsp_status_ff;

endmodule

// ===== bench/tb_tabulated_cdf_inverse_sampler_top.sv =====
// testbench for the tabulated cdf inverse sampler: directed table, then random tables and samples
// depends on tcis_pkg and the sampler top level with its divider
`timescale 1ns / 1ps

module tb_tabulated_cdf_inverse_sampler_top;
   import tcis_pkg::*;

   // one directed row; the expected response is typed in only where it is obvious
   typedef struct packed {
      logic                op;
      logic [ENERGY_W-1:0] energy;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
      logic [WEIGHT_W-1:0] rnd;
      logic                typed;
      logic [ENERGY_W-1:0] exp_energy;
      status_type          exp_status;
   } dir_row_type;

   typedef struct {
      logic [ENERGY_W-1:0] energy;
      status_type          status;
   } sample_rsp_type;

   localparam int DIR_ROWS = 25;
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      // sample straight after reset: table not ready
      '{OP_SAMPLE, 32'd0, 24'd0, 1'b0, 24'd0, 1'b1, 32'd0, STATUS_NOT_READY},
      // ascending three-point table with a zero first weight and full-scale weights
      '{OP_LOAD, 32'd100, 24'd0, 1'b0, 24'd0, 1'b0, 32'd0, STATUS_OK},
      '{OP_LOAD, 32'd200, 24'hFFFFFF, 1'b0, 24'd0, 1'b0, 32'd0, STATUS_OK},
      '{OP_LOAD, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1, 24'd0, 1'b0, 32'd0, STATUS_OK},
      '{OP_SAMPLE, 32'd0, 24'd0, 1'b0, 24'd0, 1'b0, 32'd0, STATUS_OK},
      '{OP_SAMPLE, 32'd0, 24'd0, 1'b0, 24'hFFFFFF, 1'b0, 32'd0, STATUS_OK},
      '{OP_SAMPLE, 32'd0, 24'd0, 1'b0, 24'h800000, 1'b0, 32'd0, STATUS_OK},
      '{OP_SAMPLE, 32'd0, 24'd0, 1'b0, 24'h7FFFFF, 1'b0, 32'd0, STATUS_OK},
      // load after ready starts a new, descending table
      '{OP_LOAD, 32'd500, 24'd5, 1'b0, 24'd0, 1'b0, 32'd0, STATUS_OK},
      '{OP_LOAD, 32'd10, 24'd3, 1'b1, 24'd0, 1'b0, 32'd0, STATUS_OK},
      '{OP_SAMPLE, 32'd0, 24'd0, 1'b0, 24'd0, 1'b1, 32'd0, STATUS_BELOW},
      '{OP_SAMPLE, 32'd0, 24'd0, 1'b0, 24'hFFFFFF, 1'b0, 32'd0, STATUS_OK},
      '{OP_SAMPLE, 32'd0, 24'd0, 1'b0, 24'hA00000, 1'b0, 32'd0, STATUS_OK},
      // single point, zero total: no following point
      '{OP_LOAD, 32'd7, 24'd0, 1'b1, 24'd0, 1'b0, 32'd0, STATUS_OK},
      '{OP_SAMPLE, 32'd0, 24'd0, 1'b0, 24'd5, 1'b1, 32'd0, STATUS_ABOVE},
      // single point with weight: cumulative is 1.0, every value is below it
      '{OP_LOAD, 32'd9, 24'd9, 1'b1, 24'd0, 1'b0, 32'd0, STATUS_OK},
      '{OP_SAMPLE, 32'd0, 24'd0, 1'b0, 24'd0, 1'b1, 32'd0, STATUS_BELOW},
      '{OP_SAMPLE, 32'd0, 24'd0, 1'b0, 24'hFFFFFF, 1'b1, 32'd0, STATUS_BELOW},
      // two points, zero total
      '{OP_LOAD, 32'd1, 24'd0, 1'b0, 24'd0, 1'b0, 32'd0, STATUS_OK},
      '{OP_LOAD, 32'd2, 24'd0, 1'b1, 24'd0, 1'b0, 32'd0, STATUS_OK},
      '{OP_SAMPLE, 32'd0, 24'd0, 1'b0, 24'd3, 1'b1, 32'd0, STATUS_ABOVE},
      // table being loaded but not finished
      '{OP_LOAD, 32'hFFFFFFFF, 24'hFFFFFF, 1'b0, 24'd0, 1'b0, 32'd0, STATUS_OK},
      '{OP_SAMPLE, 32'd0, 24'd0, 1'b0, 24'd0, 1'b1, 32'd0, STATUS_NOT_READY},
      '{OP_LOAD, 32'd0, 24'd1, 1'b1, 24'd0, 1'b0, 32'd0, STATUS_OK},
      '{OP_SAMPLE, 32'd0, 24'd0, 1'b0, 24'h123456, 1'b0, 32'd0, STATUS_OK}
   };

   localparam int RANDOM_ITEMS = 800;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_operation;
   logic [ENERGY_W-1:0] req_energy_point;
   logic [WEIGHT_W-1:0] req_point_weight;
   logic                req_last_point;
   logic [WEIGHT_W-1:0] req_random_value;
   logic                rsp_valid;
   logic [ENERGY_W-1:0] rsp_sampled_energy;
   logic [1:0]          rsp_sample_status;

   // predictor state: the table as the sampler should hold it
   logic [ENERGY_W-1:0] energy_tbl [TABLE_DEPTH];
   logic [31:0]         cdf_tbl [TABLE_DEPTH];
   int unsigned         point_cnt;
   bit                  tbl_ready;

   sample_rsp_type pending_samples [$];
   int unsigned    mismatch_cnt;
   int unsigned    sent_cnt;
   bit             quiet_stretch;

   tabulated_cdf_inverse_sampler_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_energy_point   (req_energy_point),
      .req_point_weight   (req_point_weight),
      .req_last_point     (req_last_point),
      .req_random_value   (req_random_value),
      .rsp_valid          (rsp_valid),
      .rsp_sampled_energy (rsp_sampled_energy),
      .rsp_sample_status  (rsp_sample_status)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic report(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatch_cnt++;
   endtask

   // turn the stored weights into a Q1.24 cumulative table
   task automatic normalize_cdf();
      logic [63:0] total;
      logic [63:0] prefix;
      total  = '0;
      prefix = '0;
      for (int k = 0; k < point_cnt; k++) total += cdf_tbl[k];
      if (total != 0) begin
         for (int k = 0; k < point_cnt; k++) begin
            prefix += cdf_tbl[k];
            cdf_tbl[k] = 32'((prefix << 24) / total);
         end
      end
      tbl_ready = 1'b1;
   endtask

   // update the table model for one accepted request; returns whether a response is due
   task automatic predict_sample(input logic op, input logic [ENERGY_W-1:0] e_in,
                                 input logic [WEIGHT_W-1:0] w_in, input logic last,
                                 input logic [WEIGHT_W-1:0] rnd,
                                 output bit has_rsp, output sample_rsp_type rsp);
      int          idx;
      bit          found;
      logic [31:0] ya, yb, ea, eb, rnd_ofs, mag;
      logic [63:0] quot;
      idx   = 0;
      found = 1'b0;
      rsp.energy = '0;
      rsp.status = STATUS_OK;
      has_rsp = (op == OP_SAMPLE);
      if (op == OP_LOAD) begin
         if (tbl_ready) begin
            tbl_ready = 1'b0;
            point_cnt = 0;
         end
         // a full table drops the point but a last flag still finalizes
         if (point_cnt < TABLE_DEPTH) begin
            energy_tbl[point_cnt] = e_in;
            cdf_tbl[point_cnt]    = 32'(w_in);
            point_cnt++;
         end
         if (last) normalize_cdf();
         return;
      end
      if (!tbl_ready) begin
         rsp.status = STATUS_NOT_READY;
         return;
      end
      for (int k = 0; k < point_cnt; k++) begin
         if (cdf_tbl[k] <= 32'(rnd)) begin
            idx   = k;
            found = 1'b1;
         end
      end
      if (!found) begin
         rsp.status = STATUS_BELOW;
         return;
      end
      if (idx + 1 >= point_cnt) begin
         rsp.status = STATUS_ABOVE;
         return;
      end
      ya = cdf_tbl[idx];
      yb = cdf_tbl[idx+1];
      if (yb <= ya) begin
         rsp.status = STATUS_ABOVE;
         return;
      end
      ea      = energy_tbl[idx];
      eb      = energy_tbl[idx+1];
      rnd_ofs = 32'(rnd) - ya;
      mag     = (eb >= ea) ? eb - ea : ea - eb;
      quot    = ({32'd0, rnd_ofs} * {32'd0, mag}) / {32'd0, yb - ya};
      // truncation is toward the lower-index energy in both directions
      rsp.energy = (eb >= ea) ? ea + quot[31:0] : ea - quot[31:0];
   endtask

   // present one request, hold it until accepted, then maybe idle a while
   task automatic send_request(input logic op, input logic [ENERGY_W-1:0] e_in,
                               input logic [WEIGHT_W-1:0] w_in, input logic last,
                               input logic [WEIGHT_W-1:0] rnd, input bit typed,
                               input sample_rsp_type typed_rsp);
      bit             has_rsp;
      sample_rsp_type rsp;
      req_operation    <= op;
      req_energy_point <= e_in;
      req_point_weight <= w_in;
      req_last_point   <= last;
      req_random_value <= rnd;
      start            <= 1'b1;
      // busy read right after the edge is its value at that edge
      do @(posedge clock); while (busy);
      sent_cnt++;
      predict_sample(op, e_in, w_in, last, rnd, has_rsp, rsp);
      if (has_rsp) pending_samples.push_back(typed ? typed_rsp : rsp);
      if (!quiet_stretch && $urandom_range(0, 99) < 10) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // random table of n points; energy shape picks ascending, descending or scattered
   task automatic load_random_table(input int n);
      int unsigned         shape, wmode;
      logic [ENERGY_W-1:0] e;
      logic [WEIGHT_W-1:0] w;
      sample_rsp_type      none;
      none.energy = '0;
      none.status = STATUS_OK;
      shape = $urandom_range(0, 3);
      wmode = $urandom_range(0, 3);
      e = $urandom();
      for (int k = 0; k < n; k++) begin
         case (shape)
            0: e = e + $urandom_range(0, 32'h00FFFFFF);
            1: e = e - $urandom_range(0, 32'h00FFFFFF);
            default: e = $urandom();
         endcase
         case (wmode)
            0: w = 24'($urandom_range(0, 15));
            1: w = ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom());
            default: w = 24'($urandom());
         endcase
         send_request(OP_LOAD, e, w, k == n - 1, 24'($urandom()), 1'b0, none);
      end
   endtask

   // response checker: a response is valid for exactly one cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_samples.size() == 0) begin
            report($sformatf("unexpected response energy %h status %0d",
                             rsp_sampled_energy, rsp_sample_status));
         end else begin
            if (rsp_sampled_energy !== pending_samples[0].energy)
               report($sformatf("energy %h, expected %h",
                                rsp_sampled_energy, pending_samples[0].energy));
            if (rsp_sample_status !== pending_samples[0].status)
               report($sformatf("status %0d, expected %0d",
                                rsp_sample_status, pending_samples[0].status));
            void'(pending_samples.pop_front());
         end
      end
   end

   // watchdog
   initial begin
      #8ms;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      sample_rsp_type typed_rsp;
      sample_rsp_type none;
      logic [WEIGHT_W-1:0] rnd;
      bit                  big_done;
      int unsigned         wait_cnt;
      none.energy = '0;
      none.status = STATUS_OK;
      big_done = 1'b0;
      mismatch_cnt = 0;
      sent_cnt = 0;
      quiet_stretch = 1'b0;
      point_cnt = 0;
      tbl_ready = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_operation    = OP_LOAD;
      req_energy_point = '0;
      req_point_weight = '0;
      req_last_point   = 1'b0;
      req_random_value = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (DIR_TABLE[i]) begin
         typed_rsp.energy = DIR_TABLE[i].exp_energy;
         typed_rsp.status = DIR_TABLE[i].exp_status;
         send_request(DIR_TABLE[i].op, DIR_TABLE[i].energy, DIR_TABLE[i].weight,
                      DIR_TABLE[i].last, DIR_TABLE[i].rnd, DIR_TABLE[i].typed, typed_rsp);
      end

      // random part: mostly well-formed tables followed by samples, some noise
      while (sent_cnt < DIR_ROWS + RANDOM_ITEMS) begin
         quiet_stretch = (sent_cnt >= 300 && sent_cnt < 450);
         if (!big_done && sent_cnt >= 500) begin
            // overfill the table so the extra points get dropped
            big_done = 1'b1;
            load_random_table(TABLE_DEPTH + 4);
         end else if ($urandom_range(0, 99) < 85) begin
            load_random_table(($urandom_range(0, 9) == 0) ? $urandom_range(2, 24)
                                                         : $urandom_range(1, 8));
         end else begin
            // noise: unrelated requests, possibly sampling a half-built table
            repeat ($urandom_range(1, 4))
               send_request(1'($urandom_range(0, 1)), $urandom(), 24'($urandom()),
                            $urandom_range(0, 3) == 0, 24'($urandom()), 1'b0, none);
         end
         repeat ($urandom_range(2, 10)) begin
            case ($urandom_range(0, 7))
               0: rnd = 24'd0;
               1: rnd = 24'hFFFFFF;
               default: rnd = 24'($urandom());
            endcase
            send_request(OP_SAMPLE, $urandom(), 24'($urandom()),
                         1'($urandom_range(0, 1)), rnd, 1'b0, none);
         end
      end
      start <= 1'b0;

      // drain outstanding responses, then allow a last normalization to finish
      wait_cnt = 0;
      while ((pending_samples.size() != 0 || busy) && wait_cnt < 20000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (100) @(posedge clock);
      if (pending_samples.size() != 0)
         report($sformatf("%0d responses never arrived", pending_samples.size()));
      if (mismatch_cnt == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
